// ===== rtl/core/rqis_pkg.sv =====
// ----------------------------------------------------------------------------
// rqis_pkg: shared definitions for the ring queue insert-swap unit
// Field widths, operation and status codes, and the control types that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package rqis_pkg;

   // Default configuration of the queue.
   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   // Port field widths.
   localparam int OPERATION_W = 2;
   localparam int VALUE_W     = 32;
   localparam int INDEX_W     = 5;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 5;

   // Operation codes.
   localparam logic [OPERATION_W-1:0] OP_PUSH_BACK   = 2'd0;
   localparam logic [OPERATION_W-1:0] OP_INSERT_SWAP = 2'd1;
   localparam logic [OPERATION_W-1:0] OP_POP_FRONT   = 2'd2;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   // How an offered item will be handled once it is accepted.
   typedef enum logic [1:0] {
      KIND_SINGLE = 2'd0,   // finishes in the accept cycle
      KIND_POP    = 2'd1,   // waits for the read data from the registered read port
      KIND_SWAP   = 2'd2    // needs a second write to finish the swap
   } kind_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic finish_pop;
      logic finish_swap;
   } rqis_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      kind_type kind;
      logic     rsp_busy;
   } rqis_stat_type;

endpackage

// ===== rtl/core/rqis_ctrl.sv =====
// ----------------------------------------------------------------------------
// rqis_ctrl: sequencing state machine
// Accepts items when idle and the result register can take a result, and
// steps through the extra state that pops and swapping inserts need.
// ----------------------------------------------------------------------------
module rqis_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  rqis_pkg::rqis_stat_type stat,
   output rqis_pkg::rqis_cmd_type  cmd
);
   import rqis_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_POP  = 3'b010,
      S_SWAP = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready       = (state_ff == S_IDLE) && !stat.rsp_busy;
   assign cmd.accept      = req_valid && req_ready;
   assign cmd.finish_pop  = (state_ff == S_POP);
   assign cmd.finish_swap = (state_ff == S_SWAP);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.accept) begin
               case (stat.kind)
                  KIND_POP:  state_in = S_POP;
                  KIND_SWAP: state_in = S_SWAP;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_POP:   state_in = S_IDLE;
         S_SWAP:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/rqis_dpath.sv =====
// ----------------------------------------------------------------------------
// rqis_dpath: queue storage, pointers and result register
// Holds the slot memory, the head and tail pointers and the entry count,
// decodes the offered item and registers each result.
// ----------------------------------------------------------------------------
module rqis_dpath #(
   parameter int DEPTH      = rqis_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = rqis_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [rqis_pkg::OPERATION_W-1:0] req_operation,
   input  logic [rqis_pkg::VALUE_W-1:0]     req_value,
   input  logic [rqis_pkg::INDEX_W-1:0]     req_index,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [rqis_pkg::VALUE_W-1:0]     rsp_popped_value,
   output logic [rqis_pkg::STATUS_W-1:0]    rsp_status,
   output logic [rqis_pkg::COUNT_W-1:0]     rsp_count,
   output logic                             rsp_is_full,
   output logic                             rsp_is_empty,
   input  rqis_pkg::rqis_cmd_type           cmd,
   output rqis_pkg::rqis_stat_type          stat
);
   import rqis_pkg::*;

   localparam int PTR_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int CMP_W   = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
   localparam int STORE_W = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;

   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);
   localparam logic [CMP_W:0]   SUM_DEPTH = (CMP_W + 1)'(DEPTH);

   logic [STORE_W-1:0] mem [DEPTH];
   logic [STORE_W-1:0] rdata_ff;

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_popped_ff, rsp_popped_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                rsp_full_ff, rsp_full_in;
   logic                rsp_empty_ff, rsp_empty_in;

   logic                q_full, q_empty;
   logic [PTR_W-1:0]    head_dec, head_inc, tail_inc;
   logic                idx_append, idx_zero;
   logic [CMP_W:0]      swap_sum, swap_mod;
   logic [PTR_W-1:0]    other_addr;
   logic [STORE_W-1:0]  value_store;
   kind_type            kind;
   logic [STATUS_W-1:0] code;
   logic                do_append, do_front, do_pop;
   logic [PTR_W-1:0]    rd_addr;
   logic                wr_en;
   logic [PTR_W-1:0]    wr_addr;
   logic [STORE_W-1:0]  wr_data;
   logic                rsp_load;

   assign q_full      = (count_ff == CNT_FULL);
   assign q_empty     = (count_ff == '0);
   assign head_dec    = (head_ff == '0) ? PTR_LAST : head_ff - PTR_W'(1);
   assign head_inc    = (head_ff == PTR_LAST) ? '0 : head_ff + PTR_W'(1);
   assign tail_inc    = (tail_ff == PTR_LAST) ? '0 : tail_ff + PTR_W'(1);
   assign idx_append  = (CMP_W'(req_index) >= CMP_W'(count_ff));
   assign idx_zero    = (req_index == '0);
   assign value_store = req_value[STORE_W-1:0];

   // The swap partner lies fewer than DEPTH slots past the new head, so a
   // single conditional subtract wraps it.
   assign swap_sum   = (CMP_W + 1)'(head_dec) + (CMP_W + 1)'(req_index);
   assign swap_mod   = (swap_sum >= SUM_DEPTH) ? swap_sum - SUM_DEPTH : swap_sum;
   assign other_addr = swap_mod[PTR_W-1:0];

   always_comb begin
      kind      = KIND_SINGLE;
      code      = ST_DONE;
      do_append = 1'b0;
      do_front  = 1'b0;
      do_pop    = 1'b0;
      rd_addr   = other_addr;
      if (req_operation == OP_PUSH_BACK || req_operation == OP_INSERT_SWAP) begin
         if (q_full) begin
            code = ST_FULL;
         end else if (req_operation == OP_PUSH_BACK || idx_append) begin
            do_append = 1'b1;
         end else begin
            do_front = 1'b1;
            if (!idx_zero) begin
               kind = KIND_SWAP;
            end
         end
      end else if (req_operation == OP_POP_FRONT) begin
         rd_addr = head_ff;
         if (q_empty) begin
            code = ST_EMPTY;
         end else begin
            do_pop = 1'b1;
            kind   = KIND_POP;
         end
      end
   end

   assign stat.kind     = kind;
   assign stat.rsp_busy = rsp_valid_ff && !rsp_ready;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (cmd.accept) begin
         if (do_append) begin
            tail_in  = tail_inc;
            count_in = count_ff + CNT_W'(1);
         end else if (do_front) begin
            head_in  = head_dec;
            count_in = count_ff + CNT_W'(1);
         end else if (do_pop) begin
            head_in  = head_inc;
            count_in = count_ff - CNT_W'(1);
         end
      end
   end

   // A front insert writes the new word at the swap partner; the word that
   // was there moves to the new head in the following cycle.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = tail_ff;
      wr_data = value_store;
      if (cmd.accept && do_append) begin
         wr_en = 1'b1;
      end else if (cmd.accept && do_front) begin
         wr_en   = 1'b1;
         wr_addr = other_addr;
      end else if (cmd.finish_swap) begin
         wr_en   = 1'b1;
         wr_addr = head_ff;
         wr_data = rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   assign rsp_load = (cmd.accept && kind == KIND_SINGLE) || cmd.finish_pop
                     || cmd.finish_swap;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_popped_in = rsp_popped_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_full_in   = rsp_full_ff;
      rsp_empty_in  = rsp_empty_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_popped_in = cmd.finish_pop ? VALUE_W'(rdata_ff) : '0;
         rsp_status_in = (cmd.finish_pop || cmd.finish_swap) ? ST_DONE : code;
         rsp_count_in  = COUNT_W'(count_in);
         rsp_full_in   = (count_in == CNT_FULL);
         rsp_empty_in  = (count_in == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_popped_ff <= rsp_popped_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_full_ff   <= rsp_full_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_value = rsp_popped_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_count        = rsp_count_ff;
   assign rsp_is_full      = rsp_full_ff;
   assign rsp_is_empty     = rsp_empty_ff;

endmodule

// ===== rtl/core/ring_queue_insert_swap_unit.sv =====
// ----------------------------------------------------------------------------
// ring_queue_insert_swap_unit: circular queue with push, insert-swap and pop
// A fixed-depth ring of words with head and tail pointers and an entry count.
// Each item is one operation and produces exactly one result item.
// ----------------------------------------------------------------------------
//
//   Channel | Handshake          | Carries
//   --------+--------------------+---------------------------------------------
//   req_    | req_valid/ready    | operation, value, index
//   rsp_    | rsp_valid/ready    | popped_value, status, count, is_full, is_empty
//
// Push back, an append through insert-swap, an insert at index zero and any
// refused or unknown operation finish in the accept cycle. A pop and an insert
// that swaps with a slot further down need a second step, set by the registered
// read port of the slot memory: the second step uses the word read in the first.
// Reset clears the pointers, the count and the result valid flag; the slot
// memory is not cleared, since only occupied slots are ever read.
// A new item is taken while a finished result waits, as long as that result
// is taken in the same cycle or the result register is empty.
// ----------------------------------------------------------------------------
module ring_queue_insert_swap_unit #(
   parameter int DEPTH      = rqis_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = rqis_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [rqis_pkg::OPERATION_W-1:0] req_operation,
   input  logic [rqis_pkg::VALUE_W-1:0]     req_value,
   input  logic [rqis_pkg::INDEX_W-1:0]     req_index,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [rqis_pkg::VALUE_W-1:0]     rsp_popped_value,
   output logic [rqis_pkg::STATUS_W-1:0]    rsp_status,
   output logic [rqis_pkg::COUNT_W-1:0]     rsp_count,
   output logic                             rsp_is_full,
   output logic                             rsp_is_empty
);
   import rqis_pkg::*;

   // The controller only sequences; every decision about an item is made by
   // the datapath from the offered fields and the current pointers.
   rqis_cmd_type  cmd;
   rqis_stat_type stat;

   rqis_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rqis_dpath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_operation    (req_operation),
      .req_value        (req_value),
      .req_index        (req_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_popped_value (rsp_popped_value),
      .rsp_status       (rsp_status),
      .rsp_count        (rsp_count),
      .rsp_is_full      (rsp_is_full),
      .rsp_is_empty     (rsp_is_empty),
      .cmd              (cmd),
      .stat             (stat)
   );

endmodule

// ===== rtl/core/rqis_checker.sv =====
// ----------------------------------------------------------------------------
// rqis_checker: port-level assertions for the ring queue insert-swap unit
// Checks the result channel for consistency between status, data and flags.
// ----------------------------------------------------------------------------
module rqis_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [rqis_pkg::VALUE_W-1:0]     rsp_popped_value,
   input logic [rqis_pkg::STATUS_W-1:0]    rsp_status,
   input logic [rqis_pkg::COUNT_W-1:0]     rsp_count,
   input logic                             rsp_is_full,
   input logic                             rsp_is_empty
);
   import rqis_pkg::*;

   // A stalled result keeps its status and data.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_popped_value))
      else $error("result changed while stalled");

   // A push refused as full reports a full queue.
   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_is_full && !rsp_is_empty)
      else $error("full refusal without full flag");

   // A pop refused as empty reports an empty queue and no data.
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |->
         rsp_is_empty && rsp_count == '0 && rsp_popped_value == '0)
      else $error("empty refusal inconsistent");

   // Data only comes with a completed operation.
   a_popped_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_popped_value != '0 |-> rsp_status == ST_DONE)
      else $error("popped data with refusal status");

   // The empty flag agrees with the count.
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_is_empty == (rsp_count == '0 && !rsp_is_full))
      else $error("empty flag disagrees with count");

endmodule

bind ring_queue_insert_swap_unit rqis_checker u_rqis_checker (.*);
